[rtl/core/zsc_pkg.sv]
`timescale 1ns / 1ps

package zsc_pkg;

  // Table geometry. Zones in use never exceed eight, so the table and the
  // per-zone flags are only as deep as the capped zone count.
  localparam int ZONES      = 8;
  localparam int SLOTS      = 4;
  localparam int RESULT_CAP = 8;
  localparam int ZONE_CAP   = (ZONES < RESULT_CAP) ? ZONES : RESULT_CAP;
  localparam int TBL_DEPTH  = ZONE_CAP * SLOTS;
  localparam int ADDR_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int SLOT_IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Command queue between the front and the back.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // Time constants.
  localparam logic [10:0] MIN_PER_DAY  = 11'd1440;
  localparam logic [10:0] MIN_PER_HOUR = 11'd60;
  localparam logic [2:0]  SUNDAY_BIT   = 3'd6;
  localparam logic [2:0]  SATURDAY     = 3'd6;
  localparam logic [2:0]  SUNDAY       = 3'd0;

  localparam logic [3:0] ZONE_COUNT_RESET = 4'd4;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_MANUAL  = 2'd2,
    ACT_ALL_OFF = 2'd3
  } action_t;

  typedef enum logic {
    REG_RUN_MODE   = 1'b0,
    REG_ZONE_COUNT = 1'b1
  } reg_idx_t;

  // One stored schedule slot.
  typedef struct packed {
    logic [10:0] start;
    logic [10:0] stop;
    logic [6:0]  days;
    logic        enable;
  } slot_t;

  // A classified input word as the back part consumes it.
  typedef struct packed {
    action_t     action;
    logic [2:0]  zone;
    logic [1:0]  slot;
    slot_t       entry;
    logic        bad_arg;
    logic        manual_value;
    logic [10:0] day_minute;
    logic [2:0]  day_bit;
    logic        trusted;
  } cmd_t;

  // Number of zones in use: zero acts as one, large values saturate.
  function automatic logic [3:0] zones_in_use(input logic [3:0] count);
    logic [3:0] n;
    n = count;
    if (n == 4'd0) begin
      n = 4'd1;
    end
    if (n > 4'(ZONE_CAP)) begin
      n = 4'(ZONE_CAP);
    end
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [2:0] zone,
                                                  input logic [SLOT_IW-1:0] slot);
    return ADDR_W'(int'(zone) * SLOTS + int'(slot));
  endfunction

endpackage

[rtl/core/zsc_front.sv]
`timescale 1ns / 1ps

module zsc_front (
  input  logic [1:0]      in_action,
  input  logic [2:0]      in_zone,
  input  logic [1:0]      in_slot,
  input  logic [10:0]     in_window_start,
  input  logic [10:0]     in_window_end,
  input  logic [7:0]      in_day_mask,
  input  logic            in_slot_enable,
  input  logic            in_manual_value,
  input  logic [4:0]      in_hour,
  input  logic [5:0]      in_minute,
  input  logic [2:0]      in_weekday,
  input  logic            in_clock_trusted,
  output zsc_pkg::cmd_t   cmd
);

  logic slot_bad;
  logic window_bad;

  // Argument checks of a slot write; the zone check waits for the back part,
  // which owns the zone count.
  always_comb begin
    slot_bad   = (5'(in_slot) >= 5'(zsc_pkg::SLOTS));
    window_bad = (in_window_start >= zsc_pkg::MIN_PER_DAY) ||
                 (in_window_end > zsc_pkg::MIN_PER_DAY) ||
                 (in_window_start >= in_window_end) ||
                 in_day_mask[7];

    cmd.action       = zsc_pkg::action_t'(in_action);
    cmd.zone         = in_zone;
    cmd.slot         = in_slot;
    cmd.entry.start  = in_window_start;
    cmd.entry.stop   = in_window_end;
    cmd.entry.days   = in_day_mask[6:0];
    cmd.entry.enable = in_slot_enable;
    cmd.bad_arg      = slot_bad || window_bad;
    cmd.manual_value = in_manual_value;
    cmd.day_minute   = 11'(in_hour) * zsc_pkg::MIN_PER_HOUR + 11'(in_minute);
    if ((in_weekday == zsc_pkg::SUNDAY) || (in_weekday > zsc_pkg::SATURDAY)) begin
      cmd.day_bit = zsc_pkg::SUNDAY_BIT;
    end else begin
      cmd.day_bit = in_weekday - 3'd1;
    end
    cmd.trusted = in_clock_trusted;
  end

endmodule

[rtl/core/zsc_cmd_fifo.sv]
`timescale 1ns / 1ps

module zsc_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  zsc_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output zsc_pkg::cmd_t rd_data,
  output logic          empty
);

  zsc_pkg::cmd_t                  mem_r [zsc_pkg::CMDQ_DEPTH];
  logic [zsc_pkg::CMDQ_PW-1:0]    wr_ptr_r;
  logic [zsc_pkg::CMDQ_PW-1:0]    rd_ptr_r;
  logic [zsc_pkg::CMDQ_CW-1:0]    count_r;
  logic                           do_wr;
  logic                           do_rd;

  assign full    = (count_r == zsc_pkg::CMDQ_CW'(zsc_pkg::CMDQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == zsc_pkg::CMDQ_PW'(zsc_pkg::CMDQ_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == zsc_pkg::CMDQ_PW'(zsc_pkg::CMDQ_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/zsc_back.sv]
`timescale 1ns / 1ps

module zsc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_index,
  input  logic [3:0]    cfg_data,
  input  zsc_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output logic          empty,
  input  logic          pop,
  output logic [2:0]    out_zone_index,
  output logic          out_drive_on,
  output logic          out_window_hit,
  output logic          out_manual_flag,
  output logic          out_status,
  output logic          out_last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR,
    ST_RD,
    ST_CMP,
    ST_EMIT
  } state_t;

  state_t                         state_r;
  zsc_pkg::cmd_t                  cmd_r;
  logic [2:0]                     z_r;
  logic [zsc_pkg::SLOT_IW-1:0]    s_r;
  logic                           run_mode_r;
  logic [3:0]                     zone_count_r;
  logic [zsc_pkg::ZONE_CAP-1:0]   manual_r;
  logic [zsc_pkg::ZONE_CAP-1:0]   window_r;
  logic [zsc_pkg::ZONE_CAP-1:0]   drive_r;
  logic [zsc_pkg::TBL_DEPTH-1:0]  slot_vld_r;
  zsc_pkg::slot_t                 tbl_r [zsc_pkg::TBL_DEPTH];
  zsc_pkg::slot_t                 rd_data_r;
  logic                           rd_vld_r;
  logic                           out_vld_r;

  logic [3:0]                     n_use;
  logic [3:0]                     n_cfg;
  logic [zsc_pkg::ZONE_CAP-1:0]   keep_mask;
  logic                           last_zone;
  logic                           cmd_oor;
  logic                           in_oor;
  logic                           tbl_wr;
  logic [zsc_pkg::ADDR_W-1:0]     wr_addr;
  logic [zsc_pkg::ADDR_W-1:0]     rd_addr;
  logic                           hit_now;
  logic                           out_free;
  logic                           emit_err;

  always_comb begin
    n_use     = zsc_pkg::zones_in_use(zone_count_r);
    n_cfg     = zsc_pkg::zones_in_use(cfg_data);
    for (int z = 0; z < zsc_pkg::ZONE_CAP; z++) begin
      keep_mask[z] = (4'(z) < n_cfg);
    end
    last_zone = ({1'b0, z_r} == (n_use - 4'd1));
    cmd_oor   = ({1'b0, cmd_r.zone} >= n_use);
    in_oor    = ({1'b0, cmd.zone} >= n_use);
    cmd_pop   = (state_r == ST_IDLE) && !cmd_empty;
    tbl_wr    = cmd_pop && (cmd.action == zsc_pkg::ACT_WRITE) && !in_oor && !cmd.bad_arg;
    wr_addr   = zsc_pkg::slot_addr(cmd.zone, zsc_pkg::SLOT_IW'(cmd.slot));
    rd_addr   = zsc_pkg::slot_addr(z_r, s_r);
    hit_now   = cmd_r.trusted && rd_vld_r && rd_data_r.enable &&
                (cmd_r.day_minute >= rd_data_r.start) &&
                (cmd_r.day_minute < rd_data_r.stop) &&
                rd_data_r.days[cmd_r.day_bit];
    out_free  = !out_vld_r || pop;
    emit_err  = cmd_oor || ((cmd_r.action == zsc_pkg::ACT_WRITE) && cmd_r.bad_arg);
  end

  assign empty = !out_vld_r;

  // Schedule table: one write port from the dispatch step, one registered read
  // port for the scan.
  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      tbl_r[wr_addr] <= cmd.entry;
    end
    rd_data_r <= tbl_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_vld_r    <= 1'b0;
      run_mode_r   <= 1'b0;
      zone_count_r <= zsc_pkg::ZONE_COUNT_RESET;
      manual_r     <= '0;
      window_r     <= '0;
      drive_r      <= '0;
      slot_vld_r   <= '0;
      rd_vld_r     <= 1'b0;
      z_r          <= '0;
      s_r          <= '0;
    end else begin
      rd_vld_r <= slot_vld_r[rd_addr];
      if (pop && out_vld_r) begin
        out_vld_r <= 1'b0;
      end

      if (cfg_wr_en) begin
        unique case (zsc_pkg::reg_idx_t'(cfg_index))
          zsc_pkg::REG_RUN_MODE: begin
            run_mode_r <= cfg_data[0];
          end
          zsc_pkg::REG_ZONE_COUNT: begin
            zone_count_r <= cfg_data;
            manual_r     <= manual_r & keep_mask;
            window_r     <= window_r & keep_mask;
            drive_r      <= drive_r & keep_mask;
          end
          default: begin
          end
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (cmd_pop) begin
            cmd_r <= cmd;
            s_r   <= '0;
            unique case (cmd.action)
              zsc_pkg::ACT_TICK: begin
                z_r     <= '0;
                state_r <= ST_RD;
              end
              zsc_pkg::ACT_ALL_OFF: begin
                z_r     <= '0;
                state_r <= ST_CLR;
              end
              zsc_pkg::ACT_WRITE: begin
                z_r <= cmd.zone;
                if (tbl_wr) begin
                  slot_vld_r[wr_addr] <= 1'b1;
                end
                state_r <= ST_EMIT;
              end
              default: begin
                z_r <= cmd.zone;
                if (!in_oor) begin
                  manual_r[cmd.zone] <= cmd.manual_value;
                end
                state_r <= ST_EMIT;
              end
            endcase
          end
        end

        ST_CLR: begin
          manual_r[z_r] <= 1'b0;
          window_r[z_r] <= 1'b0;
          drive_r[z_r]  <= 1'b0;
          state_r       <= ST_EMIT;
        end

        ST_RD: begin
          state_r <= ST_CMP;
        end

        // The first matching slot ends the zone's scan.
        ST_CMP: begin
          if (hit_now || (s_r == zsc_pkg::SLOT_IW'(zsc_pkg::SLOTS - 1))) begin
            window_r[z_r] <= hit_now;
            drive_r[z_r]  <= run_mode_r ? manual_r[z_r] : hit_now;
            state_r       <= ST_EMIT;
          end else begin
            s_r     <= s_r + 1'b1;
            state_r <= ST_RD;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            out_vld_r      <= 1'b1;
            out_zone_index <= z_r;
            if ((cmd_r.action == zsc_pkg::ACT_TICK) ||
                (cmd_r.action == zsc_pkg::ACT_ALL_OFF)) begin
              out_drive_on    <= drive_r[z_r];
              out_window_hit  <= window_r[z_r];
              out_manual_flag <= manual_r[z_r];
              out_status      <= 1'b0;
              out_last        <= last_zone;
              if (last_zone) begin
                state_r <= ST_IDLE;
              end else begin
                z_r     <= z_r + 3'd1;
                s_r     <= '0;
                state_r <= (cmd_r.action == zsc_pkg::ACT_TICK) ? ST_RD : ST_CLR;
              end
            end else begin
              out_drive_on    <= !cmd_oor && drive_r[z_r];
              out_window_hit  <= !cmd_oor && window_r[z_r];
              out_manual_flag <= !cmd_oor && manual_r[z_r];
              out_status      <= emit_err;
              out_last        <= 1'b1;
              state_r         <= ST_IDLE;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/zone_schedule_controller.sv]
`timescale 1ns / 1ps

// Zone schedule controller. Words go in through a queue-style port (push,
// full) and results come out of one (empty, pop). A time tick yields one
// result per zone in use, in zone order, with last set on the final one;
// an all-off word clears every zone in use and reports each; a slot write
// or a manual-flag word yields a single result. A tick scans the table one
// slot at a time through its registered read port, with a read step and a
// compare step per slot examined, stopping at the first match. A result
// that is not popped holds the back part until it is. The table needs no
// clearing pass: per-slot valid bits mark slots never written as disabled.
// Configuration (run mode, zone count) must be written only while no word
// is in flight; the block itself does not enforce this. Lowering the zone
// count clears the flags of the zones that drop out in the same cycle.

module zone_schedule_controller (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_zone,
  input  logic [1:0]  in_slot,
  input  logic [10:0] in_window_start,
  input  logic [10:0] in_window_end,
  input  logic [7:0]  in_day_mask,
  input  logic        in_slot_enable,
  input  logic        in_manual_value,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [2:0]  in_weekday,
  input  logic        in_clock_trusted,

  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_zone_index,
  output logic        out_drive_on,
  output logic        out_window_hit,
  output logic        out_manual_flag,
  output logic        out_status,
  output logic        out_last,

  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  zsc_pkg::cmd_t front_cmd;
  zsc_pkg::cmd_t queue_cmd;
  logic          queue_empty;
  logic          queue_pop;

  // The front part decodes a word, works out the minute of day and weekday
  // bit, and checks the slot write arguments before the word is queued.
  zsc_front u_front (
    .in_action        (in_action),
    .in_zone          (in_zone),
    .in_slot          (in_slot),
    .in_window_start  (in_window_start),
    .in_window_end    (in_window_end),
    .in_day_mask      (in_day_mask),
    .in_slot_enable   (in_slot_enable),
    .in_manual_value  (in_manual_value),
    .in_hour          (in_hour),
    .in_minute        (in_minute),
    .in_weekday       (in_weekday),
    .in_clock_trusted (in_clock_trusted),
    .cmd              (front_cmd)
  );

  // A short queue lets new words arrive while the back part is still
  // scanning the table for an earlier tick.
  zsc_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (queue_pop),
    .rd_data (queue_cmd),
    .empty   (queue_empty)
  );

  // The back part owns the schedule table, the zone flags and the
  // configuration, and drives the result register.
  zsc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (queue_cmd),
    .cmd_empty       (queue_empty),
    .cmd_pop         (queue_pop),
    .empty           (empty),
    .pop             (pop),
    .out_zone_index  (out_zone_index),
    .out_drive_on    (out_drive_on),
    .out_window_hit  (out_window_hit),
    .out_manual_flag (out_manual_flag),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

// Testbench for the zone schedule controller.
//
// A driver process pushes command words into the block: first a short table of
// directed words and register writes, then a few hundred random words. A
// monitor watches both queue ports at every rising edge. Each word that the
// block accepts runs through a local model of the schedule table and the
// per-zone flags, and the zone reports that the model gives are queued up in
// order. Each report that the block hands out is compared field by field with
// the oldest queued one. A few rows of the directed table carry a report typed
// in by hand, and that report replaces the modeled one.
//
// Both sides go idle in random bursts. Once in the run the receiver stops
// popping for a long stretch while the driver keeps offering words, so the
// block backs up and raises full. Register writes happen only while the block
// holds no word and owes no report.

module tb;

  localparam int unsigned DAY_MINUTES  = 1440;
  localparam int unsigned HOUR_MINUTES = 60;
  localparam int unsigned SUNDAY_POS   = 6;
  localparam int          RANDOM_WORDS = 240;
  localparam int          PHASE_WORDS  = 45;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 200;

  // One command word, laid out like the input ports.
  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  zone;
    logic [1:0]  slot;
    logic [10:0] win_start;
    logic [10:0] win_end;
    logic [7:0]  mask;
    logic        enable;
    logic        mval;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  weekday;
    logic        trusted;
  } zone_word_t;

  // One zone report, laid out like the output ports.
  typedef struct packed {
    logic [2:0] zone;
    logic       drive;
    logic       hit;
    logic       manual;
    logic       status;
    logic       last;
  } zone_report_t;

  // A hand-typed report for one word, or none.
  typedef struct packed {
    logic         given;
    zone_report_t value;
  } scripted_report_t;

  // One row of the directed table: either a register write or a word.
  typedef struct {
    logic              is_cfg;
    zsc_pkg::reg_idx_t cfg_reg;
    logic [3:0]        cfg_value;
    zone_word_t        word;
    scripted_report_t  answer;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [1:0]  in_action;
  logic [2:0]  in_zone;
  logic [1:0]  in_slot;
  logic [10:0] in_window_start;
  logic [10:0] in_window_end;
  logic [7:0]  in_day_mask;
  logic        in_slot_enable;
  logic        in_manual_value;
  logic [4:0]  in_hour;
  logic [5:0]  in_minute;
  logic [2:0]  in_weekday;
  logic        in_clock_trusted;
  logic        empty;
  logic        pop;
  logic [2:0]  out_zone_index;
  logic        out_drive_on;
  logic        out_window_hit;
  logic        out_manual_flag;
  logic        out_status;
  logic        out_last;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [3:0]  cfg_data;

  // Local copy of the block's state, as it stands after reset.
  zsc_pkg::slot_t sched [zsc_pkg::ZONES*zsc_pkg::SLOTS] = '{default: '0};
  logic           manual_q [zsc_pkg::ZONES] = '{default: 1'b0};
  logic           window_q [zsc_pkg::ZONES] = '{default: 1'b0};
  logic           drive_q  [zsc_pkg::ZONES] = '{default: 1'b0};
  logic           run_manual = 1'b0;
  logic [3:0]     zone_limit = 4'd4;

  // Reports owed by the block, oldest first, and the hand-typed reports
  // that go with the words on their way in, one entry per word.
  zone_report_t     zone_reports_due [$];
  scripted_report_t scripted_reports [$];

  int   error_count = 0;
  // Shared between the two sides: no idling at all, and a request for the
  // receiver to hold off for a long stretch.
  logic idle_off = 1'b0;
  logic hold_req = 1'b0;

  zone_schedule_controller uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_action        (in_action),
    .in_zone          (in_zone),
    .in_slot          (in_slot),
    .in_window_start  (in_window_start),
    .in_window_end    (in_window_end),
    .in_day_mask      (in_day_mask),
    .in_slot_enable   (in_slot_enable),
    .in_manual_value  (in_manual_value),
    .in_hour          (in_hour),
    .in_minute        (in_minute),
    .in_weekday       (in_weekday),
    .in_clock_trusted (in_clock_trusted),
    .empty            (empty),
    .pop              (pop),
    .out_zone_index   (out_zone_index),
    .out_drive_on     (out_drive_on),
    .out_window_hit   (out_window_hit),
    .out_manual_flag  (out_manual_flag),
    .out_status       (out_status),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Zones in use: a count of zero acts as one, and large counts saturate.
  function automatic int unsigned active_zones();
    int unsigned n;
    n = 32'(zone_limit);
    if (n == 0) begin
      n = 1;
    end
    if (n > zsc_pkg::ZONES) begin
      n = zsc_pkg::ZONES;
    end
    if (n > zsc_pkg::RESULT_CAP) begin
      n = zsc_pkg::RESULT_CAP;
    end
    return n;
  endfunction

  function automatic void clear_zone_flags(int unsigned z);
    manual_q[z] = 1'b0;
    window_q[z] = 1'b0;
    drive_q[z]  = 1'b0;
  endfunction

  // A register write. Lowering the zone count drops the flags of the zones
  // that fall out of use right away.
  function automatic void apply_register(logic idx, logic [3:0] value);
    int unsigned old_n;
    int unsigned z;
    if (idx == zsc_pkg::REG_RUN_MODE) begin
      run_manual = value[0];
    end else begin
      old_n = active_zones();
      zone_limit = value;
      for (z = active_zones(); z < old_n; z++) begin
        clear_zone_flags(z);
      end
    end
  endfunction

  // Works out the zone reports that one accepted word causes and queues
  // them, updating the local table and flags on the way.
  function automatic void compute_zone_reports(zone_word_t w);
    int unsigned    n;
    int unsigned    mod;
    int unsigned    bitpos;
    int unsigned    z;
    int unsigned    s;
    logic           hit;
    logic           bad;
    zsc_pkg::slot_t e;
    zone_report_t   r;
    n = active_zones();
    r = '0;
    if (w.action == zsc_pkg::ACT_TICK || w.action == zsc_pkg::ACT_ALL_OFF) begin
      // Minute of day does not wrap; weekday seven reads the Sunday bit.
      mod = w.hour * HOUR_MINUTES + w.minute;
      bitpos = (w.weekday == 0 || w.weekday > 6) ? SUNDAY_POS : w.weekday - 1;
      for (z = 0; z < n; z++) begin
        if (w.action == zsc_pkg::ACT_ALL_OFF) begin
          clear_zone_flags(z);
        end else begin
          hit = 1'b0;
          if (w.trusted) begin
            for (s = 0; s < zsc_pkg::SLOTS; s++) begin
              e = sched[z*zsc_pkg::SLOTS + s];
              if (e.enable && mod >= e.start && mod < e.stop && e.days[bitpos]) begin
                hit = 1'b1;
              end
            end
          end
          window_q[z] = hit;
          drive_q[z]  = run_manual ? manual_q[z] : hit;
        end
        r.zone   = 3'(z);
        r.drive  = drive_q[z];
        r.hit    = window_q[z];
        r.manual = manual_q[z];
        r.status = 1'b0;
        r.last   = (z + 1 == n);
        zone_reports_due.push_back(r);
      end
    end else begin
      r.zone = w.zone;
      r.last = 1'b1;
      if (w.zone >= n) begin
        r.status = 1'b1;
      end else begin
        if (w.action == zsc_pkg::ACT_WRITE) begin
          bad = w.slot >= zsc_pkg::SLOTS || w.win_start >= DAY_MINUTES ||
                w.win_end > DAY_MINUTES || w.win_start >= w.win_end || w.mask[7];
          if (!bad) begin
            e.start  = w.win_start;
            e.stop   = w.win_end;
            e.days   = w.mask[6:0];
            e.enable = w.enable;
            sched[w.zone*zsc_pkg::SLOTS + w.slot] = e;
          end
          r.status = bad;
        end else begin
          manual_q[w.zone] = w.mval;
        end
        r.drive  = drive_q[w.zone];
        r.hit    = window_q[w.zone];
        r.manual = manual_q[w.zone];
      end
      zone_reports_due.push_back(r);
    end
  endfunction

  // Word builders. Fields that an action ignores are left random.
  function automatic zone_word_t scrambled_word();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(zone_word_t)-1:0];
  endfunction

  function automatic zone_word_t tick_w(int unsigned h, int unsigned m, int unsigned wd,
                                        logic tr);
    zone_word_t w;
    w = scrambled_word();
    w.action  = zsc_pkg::ACT_TICK;
    w.hour    = 5'(h);
    w.minute  = 6'(m);
    w.weekday = 3'(wd);
    w.trusted = tr;
    return w;
  endfunction

  function automatic zone_word_t write_w(int unsigned z, int unsigned s, int unsigned st,
                                         int unsigned sp, int unsigned mk, logic en);
    zone_word_t w;
    w = scrambled_word();
    w.action    = zsc_pkg::ACT_WRITE;
    w.zone      = 3'(z);
    w.slot      = 2'(s);
    w.win_start = 11'(st);
    w.win_end   = 11'(sp);
    w.mask      = 8'(mk);
    w.enable    = en;
    return w;
  endfunction

  function automatic zone_word_t manual_w(int unsigned z, logic v);
    zone_word_t w;
    w = scrambled_word();
    w.action = zsc_pkg::ACT_MANUAL;
    w.zone   = 3'(z);
    w.mval   = v;
    return w;
  endfunction

  function automatic zone_word_t alloff_w();
    zone_word_t w;
    w = scrambled_word();
    w.action = zsc_pkg::ACT_ALL_OFF;
    return w;
  endfunction

  // Table row builders.
  function automatic stim_row_t cfg_row(zsc_pkg::reg_idx_t idx, logic [3:0] value);
    stim_row_t row;
    row.is_cfg    = 1'b1;
    row.cfg_reg   = idx;
    row.cfg_value = value;
    row.word      = '0;
    row.answer    = '0;
    return row;
  endfunction

  function automatic stim_row_t word_row(zone_word_t w);
    stim_row_t row;
    row.is_cfg    = 1'b0;
    row.cfg_reg   = zsc_pkg::REG_RUN_MODE;
    row.cfg_value = '0;
    row.word      = w;
    row.answer    = '0;
    return row;
  endfunction

  // A word with a single report typed in: zone, drive, hit, manual, status.
  function automatic stim_row_t checked_row(zone_word_t w, int unsigned z, logic drv,
                                            logic hit, logic man, logic st);
    stim_row_t row;
    row = word_row(w);
    row.answer.given = 1'b1;
    row.answer.value = {3'(z), drv, hit, man, st, 1'b1};
    return row;
  endfunction

  // A word for the random part. Most words are well formed and address zones
  // in use; a tenth are pure noise over every bit of every field.
  function automatic zone_word_t random_word();
    int unsigned n;
    int unsigned pick;
    int unsigned z;
    int unsigned st;
    int unsigned hi;
    n = active_zones();
    pick = $urandom_range(0, 99);
    z = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, n - 1);
    if (pick < 10) begin
      return scrambled_word();
    end else if (pick < 45) begin
      return tick_w($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 6),
                    $urandom_range(0, 6) != 0);
    end else if (pick < 78) begin
      if ($urandom_range(0, 9) == 0) begin
        // Broken window or mask: any value the fields allow.
        return write_w(z, $urandom_range(0, 3), $urandom_range(0, 2047),
                       $urandom_range(0, 2047), $urandom_range(0, 255),
                       1'($urandom_range(0, 1)));
      end
      st = $urandom_range(0, DAY_MINUTES - 1);
      hi = st + 720;
      if (hi > DAY_MINUTES) begin
        hi = DAY_MINUTES;
      end
      return write_w(z, $urandom_range(0, 3), st, $urandom_range(st + 1, hi),
                     $urandom_range(0, 127), $urandom_range(0, 4) != 0);
    end else if (pick < 92) begin
      return manual_w(z, 1'($urandom_range(0, 1)));
    end
    return alloff_w();
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
    error_count++;
  endtask

  // Offers one word and returns at the edge where the block takes it.
  task automatic send_word(input zone_word_t w, input scripted_report_t answer);
    scripted_reports.push_back(answer);
    in_action        <= w.action;
    in_zone          <= w.zone;
    in_slot          <= w.slot;
    in_window_start  <= w.win_start;
    in_window_end    <= w.win_end;
    in_day_mask      <= w.mask;
    in_slot_enable   <= w.enable;
    in_manual_value  <= w.mval;
    in_hour          <= w.hour;
    in_minute        <= w.minute;
    in_weekday       <= w.weekday;
    in_clock_trusted <= w.trusted;
    push             <= 1'b1;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
  endtask

  // The sender goes quiet for a random burst now and then, but not during
  // calm stretches or while the receiver is holding off.
  task automatic sender_gap();
    if (!idle_off && !hold_req && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Register writes wait until every owed report has been popped, at which
  // point the block holds no word.
  task automatic write_register(input zsc_pkg::reg_idx_t idx, input logic [3:0] value);
    push <= 1'b0;
    do begin
      @(posedge clk);
    end while (zone_reports_due.size() != 0);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Monitor. All port values are read at the rising edge, before any
  // nonblocking update of that edge lands, so the order of processes within
  // the time step does not matter. A report can never come out at the edge
  // its word goes in, so checking before modeling is safe.
  always @(posedge clk) begin : monitor
    zone_report_t     got;
    zone_report_t     want;
    zone_word_t       seen;
    scripted_report_t typed;
    if (rst_n) begin
      if (pop && !empty) begin
        got = {out_zone_index, out_drive_on, out_window_hit, out_manual_flag,
               out_status, out_last};
        if (zone_reports_due.size() == 0) begin
          report_mismatch("zone report with none due, zone", got.zone, -1);
        end else begin
          want = zone_reports_due.pop_front();
          if (got.zone != want.zone) begin
            report_mismatch("zone_index", got.zone, want.zone);
          end
          if (got.drive != want.drive) begin
            report_mismatch("drive_on", got.drive, want.drive);
          end
          if (got.hit != want.hit) begin
            report_mismatch("window_hit", got.hit, want.hit);
          end
          if (got.manual != want.manual) begin
            report_mismatch("manual_flag", got.manual, want.manual);
          end
          if (got.status != want.status) begin
            report_mismatch("status", got.status, want.status);
          end
          if (got.last != want.last) begin
            report_mismatch("last", got.last, want.last);
          end
        end
      end
      if (cfg_wr_en) begin
        apply_register(cfg_index, cfg_data);
      end
      if (push && !full) begin
        seen = {in_action, in_zone, in_slot, in_window_start, in_window_end, in_day_mask,
                in_slot_enable, in_manual_value, in_hour, in_minute, in_weekday,
                in_clock_trusted};
        compute_zone_reports(seen);
        typed = scripted_reports.pop_front();
        // Hand-typed reports are only given for single-report words, so the
        // one just queued is the one to replace.
        if (typed.given) begin
          zone_reports_due[zone_reports_due.size() - 1] = typed.value;
        end
      end
    end
  end

  // Receiver. Pops in random bursts, goes quiet in random bursts, and on
  // request holds off for a long stretch counted here.
  initial begin
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!idle_off && $urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // Driver: reset, the directed table, then the random phases.
  initial begin
    stim_row_t   directed [$];
    int          i;
    int          phase;
    logic [3:0]  count;
    rst_n            <= 1'b0;
    push             <= 1'b0;
    in_action        <= '0;
    in_zone          <= '0;
    in_slot          <= '0;
    in_window_start  <= '0;
    in_window_end    <= '0;
    in_day_mask      <= '0;
    in_slot_enable   <= 1'b0;
    in_manual_value  <= 1'b0;
    in_hour          <= '0;
    in_minute        <= '0;
    in_weekday       <= '0;
    in_clock_trusted <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= 1'b0;
    cfg_data         <= '0;

    // Out of reset: automatic mode, four zones in use, every slot disabled.
    directed.push_back(word_row(tick_w(0, 0, 0, 1'b1)));
    // Whole-day window on every day, and the very last minute of Monday.
    directed.push_back(checked_row(write_w(0, 0, 0, 1440, 'h7f, 1'b1), 0, 0, 0, 0, 0));
    directed.push_back(checked_row(write_w(1, 3, 1439, 1440, 'h01, 1'b1), 1, 0, 0, 0, 0));
    // Bad windows: start past the day, end past the day, empty window, and
    // the stray eighth mask bit.
    directed.push_back(checked_row(write_w(2, 1, 2047, 2047, 'h00, 1'b1), 2, 0, 0, 0, 1));
    directed.push_back(checked_row(write_w(2, 1, 100, 1441, 'h7f, 1'b1), 2, 0, 0, 0, 1));
    directed.push_back(checked_row(write_w(2, 1, 500, 500, 'h7f, 1'b1), 2, 0, 0, 0, 1));
    directed.push_back(checked_row(write_w(2, 1, 10, 20, 'hff, 1'b1), 2, 0, 0, 0, 1));
    // A disabled slot is still validated and stored.
    directed.push_back(checked_row(write_w(2, 2, 600, 700, 'h40, 1'b0), 2, 0, 0, 0, 0));
    directed.push_back(checked_row(write_w(2, 0, 0, 60, 'h41, 1'b1), 2, 0, 0, 0, 0));
    // Zones above the count in use are refused.
    directed.push_back(checked_row(write_w(7, 0, 0, 10, 'h01, 1'b1), 7, 0, 0, 0, 1));
    directed.push_back(checked_row(manual_w(6, 1'b1), 6, 0, 0, 0, 1));
    directed.push_back(checked_row(manual_w(3, 1'b1), 3, 0, 0, 1, 0));
    // Last minute of Monday, trusted and untrusted, then time fields at
    // their maximum with weekday seven, which reads as Sunday.
    directed.push_back(word_row(tick_w(23, 59, 1, 1'b1)));
    directed.push_back(word_row(tick_w(23, 59, 1, 1'b0)));
    directed.push_back(word_row(tick_w(31, 63, 7, 1'b1)));
    directed.push_back(word_row(tick_w(0, 59, 7, 1'b1)));
    directed.push_back(word_row(tick_w(10, 0, 0, 1'b1)));
    directed.push_back(word_row(alloff_w()));
    // Manual mode over all eight zones.
    directed.push_back(cfg_row(zsc_pkg::REG_RUN_MODE, 4'd1));
    directed.push_back(cfg_row(zsc_pkg::REG_ZONE_COUNT, 4'd8));
    directed.push_back(checked_row(manual_w(6, 1'b1), 6, 0, 0, 1, 0));
    directed.push_back(word_row(manual_w(0, 1'b1)));
    directed.push_back(word_row(tick_w(12, 0, 3, 1'b0)));
    // Dropping to two zones wipes the flags of the rest.
    directed.push_back(cfg_row(zsc_pkg::REG_ZONE_COUNT, 4'd2));
    directed.push_back(cfg_row(zsc_pkg::REG_ZONE_COUNT, 4'd8));
    directed.push_back(word_row(tick_w(12, 0, 3, 1'b1)));
    // A count of zero acts as one zone.
    directed.push_back(cfg_row(zsc_pkg::REG_ZONE_COUNT, 4'd0));
    directed.push_back(word_row(tick_w(0, 0, 0, 1'b1)));
    directed.push_back(checked_row(manual_w(1, 1'b1), 1, 0, 0, 0, 1));
    // A count past eight saturates, back in automatic mode.
    directed.push_back(cfg_row(zsc_pkg::REG_ZONE_COUNT, 4'd15));
    directed.push_back(cfg_row(zsc_pkg::REG_RUN_MODE, 4'd0));
    directed.push_back(word_row(tick_w(0, 30, 0, 1'b1)));
    directed.push_back(word_row(alloff_w()));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[k]) begin
      if (directed[k].is_cfg) begin
        write_register(directed[k].cfg_reg, directed[k].cfg_value);
      end else begin
        send_word(directed[k].word, directed[k].answer);
        sender_gap();
      end
    end

    // Random phases, each opened by new register settings once the block is
    // idle. The counts walk through the extremes as well as random values.
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i % PHASE_WORDS == 0) begin
        phase = i / PHASE_WORDS;
        case (phase)
          0: count = 4'd8;
          1: count = 4'd1;
          2: count = 4'd15;
          4: count = 4'd0;
          default: count = 4'($urandom_range(0, 15));
        endcase
        write_register(zsc_pkg::REG_RUN_MODE,
                       (phase < 4) ? 4'(phase % 2) : 4'($urandom_range(0, 1)));
        write_register(zsc_pkg::REG_ZONE_COUNT, count);
      end
      // A calm stretch in the middle, and none at all near the end.
      idle_off = (i >= 120 && i < 150) || (i >= 200);
      // With eight zones in use, ticks pile up reports fast while the
      // receiver holds off.
      if (i == 20) begin
        hold_req = 1'b1;
      end
      send_word(random_word(), '0);
      sender_gap();
    end
    push <= 1'b0;

    while (zone_reports_due.size() != 0) begin
      @(posedge clk);
    end
    // Let any stray report surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
rtl/core/zsc_pkg.sv
rtl/core/zsc_front.sv
rtl/core/zsc_cmd_fifo.sv
rtl/core/zsc_back.sv
rtl/core/zone_schedule_controller.sv
bench/tb.sv
